// ===== design/ppdh_pkg.sv =====
// ----------------------------------------------------------------------------
// ppdh_pkg
// Shared types for the partial pair-distance histogram core.
// ----------------------------------------------------------------------------
package ppdh_pkg;

  typedef enum logic [1:0] {
    OP_ACCUMULATE = 2'd0,
    OP_READ       = 2'd1
  } op_code_t;

  typedef struct packed {
    logic               operation;
    logic [2:0]         pair_slot;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic               same_atom;
    logic               same_molecule;
    logic [7:0]         read_bin;
  } request_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic        counted;
    logic [7:0]  hit_bin;
  } result_t;

  typedef enum logic [2:0] {
    REG_BOX_X, REG_BOX_Y, REG_BOX_Z,
    REG_INV_BOX_X, REG_INV_BOX_Y, REG_INV_BOX_Z,
    REG_INV_BIN_WIDTH, REG_INTERACTION_MODE
  } reg_index_t;

  localparam logic [1:0] MODE_ALL   = 2'd0;
  localparam logic [1:0] MODE_INTER = 2'd1;
  localparam logic [1:0] MODE_INTRA = 2'd2;

  typedef struct packed {
    logic [30:0] box_x;
    logic [30:0] box_y;
    logic [30:0] box_z;
    logic [31:0] inv_box_x;
    logic [31:0] inv_box_y;
    logic [31:0] inv_box_z;
    logic [31:0] inv_bin_width;
    logic [1:0]  interaction_mode;
  } cfg_t;

  // Classification made by the front end
  typedef enum logic [1:0] {
    KIND_ACC       = 2'd0,  // accumulate, passes all filters
    KIND_SKIP      = 2'd1,  // accumulate, rejected
    KIND_READ      = 2'd2,  // read and clear a stored counter
    KIND_READ_NONE = 2'd3   // read of a slot or bin outside the store
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         pair_slot;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [7:0]         read_bin;
  } work_item_t;

  typedef struct packed {
    logic       valid;
    work_item_t item;
  } queue_head_t;

endpackage

// ===== design/ppdh_front.sv =====
// ----------------------------------------------------------------------------
// ppdh_front
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ppdh_front #(
  parameter int NUM_PAIR_SLOTS = 8,
  parameter int NUM_BINS       = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ppdh_pkg::request_t   request,
  input  logic [1:0]           mode,
  output logic                 full,
  output ppdh_pkg::queue_head_t head,
  input  logic                 take
);
  import ppdh_pkg::*;

  localparam int QDEPTH = 2;

  work_item_t entry [QDEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  work_item_t incoming;
  logic       slot_ok, rb_ok, reject;
  logic       do_push, do_take;

  always_comb begin
    slot_ok = 32'(request.pair_slot) < NUM_PAIR_SLOTS;
    rb_ok   = 32'(request.read_bin) < NUM_BINS;
    reject  = !slot_ok || request.same_atom
              || (mode == MODE_INTER && request.same_molecule)
              || (mode == MODE_INTRA && !request.same_molecule);
    incoming.pair_slot = request.pair_slot;
    incoming.first_x   = request.first_x;
    incoming.first_y   = request.first_y;
    incoming.first_z   = request.first_z;
    incoming.second_x  = request.second_x;
    incoming.second_y  = request.second_y;
    incoming.second_z  = request.second_z;
    incoming.read_bin  = request.read_bin;
    if (request.operation) begin
      incoming.kind = (slot_ok && rb_ok) ? KIND_READ : KIND_READ_NONE;
    end else begin
      incoming.kind = reject ? KIND_SKIP : KIND_ACC;
    end
  end

  assign full       = (count == 2'(QDEPTH));
  assign do_push    = push && !full;
  assign do_take    = take && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_take);
    end
  end

endmodule

// ===== design/ppdh_sqrt.sv =====
// ----------------------------------------------------------------------------
// ppdh_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ppdh_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] x;
  logic [34:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [34:0] rem_sh, trial;

  always_comb begin
    rem_sh = {rem[32:0], x[63:62]};
    trial  = {1'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      x    <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      x   <= {x[61:0], 2'b00};
      cnt <= cnt + 5'd1;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/ppdh_back.sv =====
// ----------------------------------------------------------------------------
// ppdh_back
// Sequencer: minimum-image wrap, distance, bin, histogram update or read and clear.
// ----------------------------------------------------------------------------
module ppdh_back #(
  parameter int NUM_PAIR_SLOTS = 8,
  parameter int NUM_BINS       = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ppdh_pkg::cfg_t        cfg,
  input  ppdh_pkg::queue_head_t head,
  output logic                  take,
  output logic                  clearing,
  output logic                  empty,
  output ppdh_pkg::result_t     result,
  input  logic                  pop
);
  import ppdh_pkg::*;

  localparam int DEPTH  = NUM_PAIR_SLOTS * NUM_BINS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_MUL  = 12'b000000000010,
    S_WRAP = 12'b000000000100,
    S_DIF  = 12'b000000001000,
    S_SQR  = 12'b000000010000,
    S_SUM  = 12'b000000100000,
    S_ROOT = 12'b000001000000,
    S_BINM = 12'b000010000000,
    S_CHK  = 12'b000100000000,
    S_RD   = 12'b001000000000,
    S_WR   = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  state_t      state, state_next;
  kind_t       kind;
  logic [2:0]  slot;
  logic [32:0] mag  [3];
  logic [63:0] prod [3];
  logic [47:0] nbox [3];
  logic [47:0] wmag [3];
  logic [63:0] sq   [3];
  logic [30:0] box  [3];
  logic [31:0] inv  [3];
  logic [32:0] dsub [3];
  logic [16:0] nimg [3];
  logic [48:0] wdif [3];
  logic [65:0] sum3;
  logic [63:0] r2;
  logic [31:0] bin_hi;
  logic [31:0] root;
  logic        root_done;
  logic [ADDR_W-1:0] addr, clr_addr;
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0] mem_wdata;
  result_t     res_work;
  logic        out_valid;
  logic        out_free;

  assign box[0] = cfg.box_x;
  assign box[1] = cfg.box_y;
  assign box[2] = cfg.box_z;
  assign inv[0] = cfg.inv_box_x;
  assign inv[1] = cfg.inv_box_y;
  assign inv[2] = cfg.inv_box_z;

  // Per-axis difference magnitude taken straight from the queue head
  always_comb begin
    dsub[0] = {head.item.second_x[31], head.item.second_x}
            - {head.item.first_x[31], head.item.first_x};
    dsub[1] = {head.item.second_y[31], head.item.second_y}
            - {head.item.first_y[31], head.item.first_y};
    dsub[2] = {head.item.second_z[31], head.item.second_z}
            - {head.item.first_z[31], head.item.first_z};
    for (int a = 0; a < 3; a++) begin
      nimg[a] = 17'(prod[a][63:48]) + 17'(prod[a][47]);
      wdif[a] = {16'b0, mag[a]} - {1'b0, nbox[a]};
    end
    sum3 = 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]);
    r2   = (sum3[65:64] != 2'b00) ? '1 : sum3[63:0];
  end

  ppdh_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SUM),
    .radicand (r2),
    .done     (root_done),
    .root     (root)
  );

  assign out_free = !out_valid || pop;
  assign take     = (state == S_IDLE) && head.valid && !clearing;
  assign empty    = !out_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (head.item.kind)
            KIND_ACC:  state_next = S_MUL;
            KIND_READ: state_next = S_RD;
            default:   state_next = S_OUT;
          endcase
        end
      end
      S_MUL:  state_next = S_WRAP;
      S_WRAP: state_next = S_DIF;
      S_DIF:  state_next = S_SQR;
      S_SQR:  state_next = S_SUM;
      S_SUM:  state_next = S_ROOT;
      S_ROOT: if (root_done) state_next = S_BINM;
      S_BINM: state_next = S_CHK;
      S_CHK:  state_next = (bin_hi < 32'(NUM_BINS)) ? S_RD : S_OUT;
      S_RD:   state_next = S_WR;
      S_WR:   state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Single write port shared by the clearing pass and the update or read-clear write
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = (state == S_WR);
      mem_waddr = addr;
      if (kind == KIND_ACC) begin
        mem_wdata = (rdata == '1) ? rdata : rdata + 32'd1;
      end else begin
        mem_wdata = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(DEPTH - 1)) clearing <= 1'b0;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end

    if (state == S_OUT && out_free) begin
      result <= res_work;
    end

    case (state)
      S_IDLE: begin
        kind <= head.item.kind;
        slot <= head.item.pair_slot;
        for (int a = 0; a < 3; a++) begin
          mag[a] <= dsub[a][32] ? 33'(-dsub[a]) : dsub[a];
        end
        addr <= ADDR_W'(32'(head.item.pair_slot) * NUM_BINS
                        + 32'(head.item.read_bin));
        res_work.bin_count <= '0;
        res_work.counted   <= 1'b0;
        res_work.hit_bin   <= (head.item.kind == KIND_READ
                               || head.item.kind == KIND_READ_NONE)
                              ? head.item.read_bin : 8'd0;
      end
      S_MUL: begin
        for (int a = 0; a < 3; a++) begin
          prod[a] <= mag[a][32] ? {inv[a], 32'b0} : 64'(mag[a][31:0]) * 64'(inv[a]);
        end
      end
      S_WRAP: begin
        for (int a = 0; a < 3; a++) begin
          nbox[a] <= 48'(nimg[a]) * 48'(box[a]);
        end
      end
      S_DIF: begin
        for (int a = 0; a < 3; a++) begin
          wmag[a] <= wdif[a][48] ? 48'(-wdif[a]) : wdif[a][47:0];
        end
      end
      S_SQR: begin
        for (int a = 0; a < 3; a++) begin
          sq[a] <= (wmag[a][47:32] != 16'd0) ? '1
                   : 64'(wmag[a][31:0]) * 64'(wmag[a][31:0]);
        end
      end
      S_BINM: begin
        bin_hi <= 32'((64'(root) * 64'(cfg.inv_bin_width)) >> 32);
      end
      S_CHK: begin
        addr <= ADDR_W'(32'(slot) * NUM_BINS + bin_hi);
      end
      S_WR: begin
        if (kind == KIND_ACC) begin
          res_work.counted <= 1'b1;
          res_work.hit_bin <= bin_hi[7:0];
        end else begin
          res_work.bin_count <= rdata;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/partial_pair_distance_histogram_core.sv =====
// ----------------------------------------------------------------------------
// partial_pair_distance_histogram_core
// Pair-distance histogram per pair slot with minimum-image wrap.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive request and raise push; the item is taken on a clock
//   edge with push high and full low. Result queue: result is valid while
//   empty is low and is taken on an edge with pop high.
//   Config: cfg_we/cfg_index/cfg_data write one register per edge; write
//   only while the core is idle.
// Flow:
//   The front end queues up to two items; the back end runs one at a time.
//   An accumulate item goes through the wrap, square and bit-serial square
//   root steps, then the bin and read-modify-write steps. A read item does a
//   memory read and clear. Rejected items and reads outside the store go
//   straight to the output, and an out-of-range bin skips the update.
// Reset:
//   rst is synchronous. After it the core clears all NUM_PAIR_SLOTS*NUM_BINS
//   counters (2048 by default) of the histogram store, one counter per cycle;
//   full stays high until that pass ends.
// Stall:
//   While the result is not popped the back end holds its finished item;
//   the front queue keeps accepting until both entries are in use.
// ----------------------------------------------------------------------------
module partial_pair_distance_histogram_core #(
  parameter int NUM_PAIR_SLOTS = 8,
  parameter int NUM_BINS       = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ppdh_pkg::request_t  request,
  output logic                empty,
  input  logic                pop,
  output ppdh_pkg::result_t   result,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import ppdh_pkg::*;

  cfg_t        cfg;
  queue_head_t head;
  logic        take;
  logic        clearing;
  logic        front_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_x            <= 31'd65536;
      cfg.box_y            <= 31'd65536;
      cfg.box_z            <= 31'd65536;
      cfg.inv_box_x        <= '1;
      cfg.inv_box_y        <= '1;
      cfg.inv_box_z        <= '1;
      cfg.inv_bin_width    <= 32'd65536;
      cfg.interaction_mode <= MODE_ALL;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_BOX_X:            cfg.box_x            <= cfg_data[30:0];
        REG_BOX_Y:            cfg.box_y            <= cfg_data[30:0];
        REG_BOX_Z:            cfg.box_z            <= cfg_data[30:0];
        REG_INV_BOX_X:        cfg.inv_box_x        <= cfg_data;
        REG_INV_BOX_Y:        cfg.inv_box_y        <= cfg_data;
        REG_INV_BOX_Z:        cfg.inv_box_z        <= cfg_data;
        REG_INV_BIN_WIDTH:    cfg.inv_bin_width    <= cfg_data;
        REG_INTERACTION_MODE: cfg.interaction_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // No items enter while the store is being cleared
  assign full = front_full || clearing;

  ppdh_front #(
    .NUM_PAIR_SLOTS (NUM_PAIR_SLOTS),
    .NUM_BINS       (NUM_BINS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push && !clearing),
    .request (request),
    .mode    (cfg.interaction_mode),
    .full    (front_full),
    .head    (head),
    .take    (take)
  );

  ppdh_back #(
    .NUM_PAIR_SLOTS (NUM_PAIR_SLOTS),
    .NUM_BINS       (NUM_BINS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .take     (take),
    .clearing (clearing),
    .empty    (empty),
    .result   (result),
    .pop      (pop)
  );

endmodule

// ===== sim/tb_partial_pair_distance_histogram_core.sv =====
// ----------------------------------------------------------------------------
// tb_partial_pair_distance_histogram_core
// Self-checking bench: directed and random pair/read items are pushed into the
// core, each popped result is compared with a bit-accurate histogram predictor.
// ----------------------------------------------------------------------------
module tb_partial_pair_distance_histogram_core;
  import ppdh_pkg::*;

  localparam int SLOTS = 8;
  localparam int BINS  = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  request_t request = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  partial_pair_distance_histogram_core i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: shadow registers and histogram copy
  logic [30:0] box_len [3];
  logic [31:0] inv_box [3];
  logic [31:0] inv_bw;
  logic [1:0]  mode;
  logic [31:0] hist_model [SLOTS*BINS];

  result_t pending_results [$];
  int mismatches = 0;
  int n_items = 0;
  int n_counted = 0;
  int n_reads = 0;
  bit hold_off = 1'b0;
  int hold_cycles = 0;
  bit stall_pat = 1'b0;

  // Minimum-image wrapped magnitude for one axis
  function automatic logic [63:0] wrap_mag(logic signed [31:0] a,
                                           logic signed [31:0] b,
                                           logic [30:0] bl, logic [31:0] ib);
    logic signed [63:0] d;
    logic [63:0] m, p, n;
    logic signed [63:0] w;
    d = 64'(b) - 64'(a);
    m = (d < 0) ? -d : d;
    p = m * 64'(ib);
    n = p >> 48;
    if (p[47]) n = n + 1;
    w = $signed(m) - $signed(n * 64'(bl));
    return (w < 0) ? -w : w;
  endfunction

  function automatic logic [63:0] sq_sat(logic [63:0] m);
    return (m >= 64'h1_0000_0000) ? '1 : m * m;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] rem, res, bt;
    rem = x; res = 0; bt = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Advances the histogram copy by one item and returns the result it gives
  function automatic result_t histogram_step(request_t rq);
    result_t o;
    logic [63:0] r2, r, bn;
    int idx;
    o = '0;
    if (rq.operation == OP_READ[0]) begin
      o.hit_bin = rq.read_bin;
      idx = rq.pair_slot * BINS + rq.read_bin;
      o.bin_count = hist_model[idx];
      hist_model[idx] = '0;
      return o;
    end
    if (rq.same_atom) return o;
    if (mode == MODE_INTER && rq.same_molecule) return o;
    if (mode == MODE_INTRA && !rq.same_molecule) return o;
    r2 = sq_sat(wrap_mag(rq.first_x, rq.second_x, box_len[0], inv_box[0]));
    r2 = add_sat(r2, sq_sat(wrap_mag(rq.first_y, rq.second_y, box_len[1], inv_box[1])));
    r2 = add_sat(r2, sq_sat(wrap_mag(rq.first_z, rq.second_z, box_len[2], inv_box[2])));
    r = root64(r2);
    bn = (r * 64'(inv_bw)) >> 32;
    if (bn < BINS) begin
      idx = rq.pair_slot * BINS + int'(bn);
      if (hist_model[idx] != '1) hist_model[idx] = hist_model[idx] + 1;
      o.counted = 1'b1;
      o.hit_bin = bn[7:0];
    end
    return o;
  endfunction

  // Register write while idle; shadow copy follows
  task automatic write_reg(reg_index_t ix, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (ix)
      REG_BOX_X, REG_BOX_Y, REG_BOX_Z: box_len[int'(ix)] = v[30:0];
      REG_INV_BOX_X, REG_INV_BOX_Y, REG_INV_BOX_Z: inv_box[int'(ix) - 3] = v;
      REG_INV_BIN_WIDTH: inv_bw = v;
      default: mode = v[1:0];
    endcase
  endtask

  // One box setting on all three axes: length and its reciprocal
  task automatic set_box(logic [30:0] bl, logic [31:0] ib);
    write_reg(REG_BOX_X, 32'(bl)); write_reg(REG_BOX_Y, 32'(bl));
    write_reg(REG_BOX_Z, 32'(bl));
    write_reg(REG_INV_BOX_X, ib); write_reg(REG_INV_BOX_Y, ib);
    write_reg(REG_INV_BOX_Z, ib);
  endtask

  // Sends one item; prediction is made at the accepting edge
  task automatic send_item(request_t rq);
    @(negedge clk);
    request <= rq;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_results = {pending_results, histogram_step(rq)};
    n_items++;
    if (rq.operation == OP_READ[0]) n_reads++;
    @(negedge clk);
    push <= 1'b0;
  endtask

  // Waits until every expected item has come back, plus a settle margin
  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Random gaps between bursts
  task automatic sender_gap();
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'sh8000_0000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    endcase
  endfunction

  function automatic request_t rand_pair();
    request_t rq;
    rq = '0;
    rq.operation = OP_ACCUMULATE[0];
    rq.pair_slot = 3'($urandom);
    rq.first_x = rand_pos(); rq.first_y = rand_pos(); rq.first_z = rand_pos();
    rq.second_x = rand_pos(); rq.second_y = rand_pos(); rq.second_z = rand_pos();
    rq.same_atom = ($urandom_range(0, 9) == 0);
    rq.same_molecule = 1'($urandom);
    rq.read_bin = 8'($urandom);
    return rq;
  endfunction

  function automatic request_t read_req(logic [2:0] sl, logic [7:0] bn);
    request_t rq;
    rq = rand_pair();
    rq.operation = OP_READ[0];
    rq.pair_slot = sl;
    rq.read_bin = bn;
    return rq;
  endfunction

  // Result checker, oldest expectation first
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", result);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.counted) n_counted++;
        if (result.bin_count !== exp_r.bin_count || result.counted !== exp_r.counted ||
            result.hit_bin !== exp_r.hit_bin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cnt=%0d counted=%0b bin=%0d, got cnt=%0d counted=%0b bin=%0d",
                     exp_r.bin_count, exp_r.counted, exp_r.hit_bin,
                     result.bin_count, result.counted, result.hit_bin);
        end
      end
    end
  end

  // Receiver: own stall pattern, plus a long counted hold-off on request
  always @(negedge clk) begin
    if (hold_off) begin
      pop <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      if ($urandom_range(0, 31) == 0) stall_pat <= ~stall_pat;
      pop <= stall_pat ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 4) != 0);
    end
  end

  task automatic test_directed();
    request_t rq;
    // extremes of positions across default box
    rq = rand_pair(); rq.same_atom = 0; rq.pair_slot = 0;
    rq.first_x = 32'sh7FFF_FFFF; rq.second_x = 32'sh8000_0000;
    rq.first_y = 0; rq.second_y = 0; rq.first_z = 0; rq.second_z = 0;
    send_item(rq);
    rq.same_atom = 1; send_item(rq);                 // self pair
    rq.same_atom = 0; rq.second_x = 32'sh0000_8000; rq.first_x = 0;
    send_item(rq);                                   // half-box rounding
    rq.pair_slot = 7; rq.second_x = 32'sh7FFF_FFFF; rq.first_x = 32'sh8000_0000;
    rq.second_y = 32'sh7FFF_FFFF; rq.first_y = 32'sh8000_0000;
    send_item(rq);
    send_item(read_req(3'd0, 8'd0));
    send_item(read_req(3'd7, 8'd255));
    send_item(read_req(3'd3, 8'hAA));
    drain();
    // huge box, no wrap: distance overflow and bin out of range
    set_box(31'h7FFF_FFFF, 32'd0);
    write_reg(REG_INV_BIN_WIDTH, 32'hFFFF_FFFF);
    rq.second_z = 32'sh7FFF_FFFF; rq.first_z = 32'sh8000_0000;
    send_item(rq);
    rq.second_x = 0; rq.first_x = 0; rq.second_y = 0; rq.first_y = 0;
    rq.second_z = 0; rq.first_z = 0;
    send_item(rq);                                   // zero distance, bin 0
    drain();
    write_reg(REG_INV_BIN_WIDTH, 32'd0);
    rq.second_x = 32'sh7FFF_FFFF;
    send_item(rq);
    send_item(read_req(3'd7, 8'd0));
    drain();
    // interaction modes, unused mode included
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_INTERACTION_MODE, m);
      rq.same_molecule = 0; send_item(rq);
      rq.same_molecule = 1; send_item(rq);
      drain();
    end
    send_item(read_req(3'd7, 8'd0));
    drain();
  endtask

  task automatic test_random(int count);
    request_t rq;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0)
        rq = read_req(3'($urandom), ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(0, 15)));
      else
        rq = rand_pair();
      send_item(rq);
      sender_gap();
    end
  endtask

  // Fill the core while the receiver holds off
  task automatic test_backpressure();
    hold_off = 1'b1;
    hold_cycles = 0;
    fork
      test_random(20);
      begin
        while (hold_cycles < 400) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  task automatic run_setting(logic [30:0] bl, logic [31:0] ib, logic [31:0] bw,
                             logic [1:0] md, int count);
    set_box(bl, ib);
    write_reg(REG_INV_BIN_WIDTH, bw);
    write_reg(REG_INTERACTION_MODE, 32'(md));
    test_random(count);
    drain();
  endtask

  initial begin
    box_len = '{31'd65536, 31'd65536, 31'd65536};
    inv_box = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    inv_bw = 32'd65536;
    mode = MODE_ALL;
    foreach (hist_model[k]) hist_model[k] = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    // box 4.0, bin width 1/64
    run_setting(31'd262144, 32'h4000_0000, 32'd4194304, MODE_ALL, 250);
    test_backpressure();
    run_setting(31'd131072, 32'h8000_0000, 32'd2097152, MODE_INTER, 200);
    run_setting(31'd65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF, MODE_INTRA, 150);
    run_setting(31'd0, 32'hFFFF_FFFF, 32'd100000, 2'd3, 150);
    run_setting(31'd262144, 32'h4000_0000, 32'd4194304, MODE_ALL, 200);
    // read the low bins back so stored counts are checked
    for (int s = 0; s < SLOTS; s++)
      for (int b = 0; b < 16; b++) send_item(read_req(3'(s), 8'(b)));
    drain();
    $display("ran %0d items (%0d reads, %0d counted pairs) across several box, bin and mode setups",
             n_items, n_reads, n_counted);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d left over", mismatches, pending_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end
endmodule
